@@ hw/rtl/bc_pkg.sv @@
package bc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int N_COORD        = 12;
    localparam int OUT_FRAC       = 16;
    localparam int WEIGHT_W       = 32;
    localparam int N_WEIGHT       = 3;

    localparam int USER_DEGEN = 0;
    localparam int USER_SAT   = 1;

endpackage

@@ hw/rtl/barycentric_coordinates_top.sv @@
// Channel  Ports                     Word contents (lowest bits first)
// s_       tvalid tready tdata       point xyz, vertex A xyz, B xyz, C xyz
// m_       tvalid tready tdata tuser weight_u, weight_v, weight_w | degenerate, saturated
//
// One word enters every cycle while the output is not held; the latency is set mostly
// by the two restoring dividers, which run side by side at one quotient bit per stage.
// Reset is synchronous and clears only the valid bits of the pipeline.
// When the output word is held, the whole pipeline holds with it; nothing is lost.
module barycentric_coordinates_top
    import bc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // point_x, point_y, point_z, vertex_a_x..z, vertex_b_x..z, vertex_c_x..z
    input  logic [((N_COORD*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // weight_u, weight_v, weight_w
    output logic [N_WEIGHT*WEIGHT_W-1:0]           m_tdata,
    // degenerate, saturated
    output logic [1:0]                             m_tuser
);

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int HW   = (DOTW + 1) / 2;
    localparam int PPW  = 2 * (HW + 1);
    localparam int MW   = 2 * DOTW;
    localparam int NW   = MW + 1;
    localparam int QW   = NW + OUT_FRAC;
    localparam int XW   = QW + 3;

    localparam int DX [5] = '{0, 0, 1, 2, 2};
    localparam int DY [5] = '{0, 1, 1, 0, 1};
    localparam int PA [6] = '{0, 1, 2, 1, 0, 1};
    localparam int PB [6] = '{2, 1, 3, 4, 4, 3};

    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic signed [COORD_BITS-1:0] crd [N_COORD];
    always_comb begin
        for (int k = 0; k < N_COORD; k++) begin
            crd[k] = s_tdata[k*COORD_BITS +: COORD_BITS];
        end
    end

    // Stage 1: edge vectors.
    logic                 v1_reg;
    logic signed [DW-1:0] e_reg [3][3];
    // Stage 2: coordinate products.
    logic                 v2_reg;
    logic signed [PW-1:0] p_reg [15];
    // Stage 3: dot products.
    logic                   v3_reg;
    logic signed [DOTW-1:0] dot_reg [5];
    // Stage 4: partial products of the wide products.
    logic                  v4_reg;
    logic signed [PPW-1:0] pp_reg [6][4];
    // Stage 5: wide products.
    logic                 v5_reg;
    logic signed [MW-1:0] prod_reg [6];
    // Stage 6: denominator and numerators.
    logic                 v6_reg;
    logic signed [NW-1:0] den_reg, nv_reg, nw_reg;

    logic signed [HW:0] lo_a [6], hi_a [6], lo_b [6], hi_b [6];
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            lo_a[j] = $signed({1'b0, dot_reg[PA[j]][HW-1:0]});
            lo_b[j] = $signed({1'b0, dot_reg[PB[j]][HW-1:0]});
            hi_a[j] = (HW+1)'(dot_reg[PA[j]] >>> HW);
            hi_b[j] = (HW+1)'(dot_reg[PB[j]] >>> HW);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ax = 0; ax < 3; ax++) begin
                e_reg[0][ax] <= DW'(crd[6+ax]) - DW'(crd[3+ax]);
                e_reg[1][ax] <= DW'(crd[9+ax]) - DW'(crd[3+ax]);
                e_reg[2][ax] <= DW'(crd[ax])   - DW'(crd[3+ax]);
            end
            for (int d = 0; d < 5; d++) begin
                for (int ax = 0; ax < 3; ax++) begin
                    p_reg[d*3+ax] <= PW'(e_reg[DX[d]][ax]) * PW'(e_reg[DY[d]][ax]);
                end
                dot_reg[d] <= DOTW'(p_reg[d*3]) + DOTW'(p_reg[d*3+1]) + DOTW'(p_reg[d*3+2]);
            end
            for (int j = 0; j < 6; j++) begin
                pp_reg[j][0] <= PPW'(hi_a[j]) * PPW'(hi_b[j]);
                pp_reg[j][1] <= PPW'(hi_a[j]) * PPW'(lo_b[j]);
                pp_reg[j][2] <= PPW'(lo_a[j]) * PPW'(hi_b[j]);
                pp_reg[j][3] <= PPW'(lo_a[j]) * PPW'(lo_b[j]);
                prod_reg[j] <= (MW'(pp_reg[j][0]) <<< (2*HW))
                             + ((MW'(pp_reg[j][1]) + MW'(pp_reg[j][2])) <<< HW)
                             + MW'(pp_reg[j][3]);
            end
            den_reg <= NW'(prod_reg[0]) - NW'(prod_reg[1]);
            nv_reg  <= NW'(prod_reg[2]) - NW'(prod_reg[3]);
            nw_reg  <= NW'(prod_reg[4]) - NW'(prod_reg[5]);
        end
    end

    // Divider pipeline: index 0 is loaded from the magnitudes, index QW holds the quotients.
    logic          dv_reg   [QW+1];
    logic          dg_reg   [QW+1];
    logic          sv_reg   [QW+1];
    logic          sw_reg   [QW+1];
    logic [NW-1:0] dm_reg   [QW+1];
    logic [NW-1:0] rv_reg   [QW+1];
    logic [NW-1:0] rw_reg   [QW+1];
    logic [QW-1:0] qv_reg   [QW+1];
    logic [QW-1:0] qw_reg   [QW+1];
    logic [NW-1:0] rv_next  [QW];
    logic [NW-1:0] rw_next  [QW];
    logic [QW-1:0] qv_next  [QW];
    logic [QW-1:0] qw_next  [QW];

    logic [NW:0] tv, tw, sv, sw;
    always_comb begin
        for (int i = 0; i < QW; i++) begin
            tv = {rv_reg[i], qv_reg[i][QW-1]};
            tw = {rw_reg[i], qw_reg[i][QW-1]};
            sv = tv - {1'b0, dm_reg[i]};
            sw = tw - {1'b0, dm_reg[i]};
            rv_next[i] = sv[NW] ? tv[NW-1:0] : sv[NW-1:0];
            rw_next[i] = sw[NW] ? tw[NW-1:0] : sw[NW-1:0];
            qv_next[i] = {qv_reg[i][QW-2:0], !sv[NW]};
            qw_next[i] = {qw_reg[i][QW-2:0], !sw[NW]};
        end
    end

    logic [NW-1:0] den_mag, nv_mag, nw_mag;
    assign den_mag = den_reg[NW-1] ? (~den_reg + 1'b1) : den_reg;
    assign nv_mag  = nv_reg[NW-1]  ? (~nv_reg + 1'b1)  : nv_reg;
    assign nw_mag  = nw_reg[NW-1]  ? (~nw_reg + 1'b1)  : nw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dg_reg[0] <= (den_reg == '0);
            sv_reg[0] <= nv_reg[NW-1] ^ den_reg[NW-1];
            sw_reg[0] <= nw_reg[NW-1] ^ den_reg[NW-1];
            dm_reg[0] <= den_mag;
            rv_reg[0] <= '0;
            rw_reg[0] <= '0;
            qv_reg[0] <= {nv_mag, {OUT_FRAC{1'b0}}};
            qw_reg[0] <= {nw_mag, {OUT_FRAC{1'b0}}};
            for (int i = 0; i < QW; i++) begin
                dg_reg[i+1] <= dg_reg[i];
                sv_reg[i+1] <= sv_reg[i];
                sw_reg[i+1] <= sw_reg[i];
                dm_reg[i+1] <= dm_reg[i];
                rv_reg[i+1] <= rv_next[i];
                rw_reg[i+1] <= rw_next[i];
                qv_reg[i+1] <= qv_next[i];
                qw_reg[i+1] <= qw_next[i];
            end
        end
    end

    // Final stages: signed quotients, then the first weight, saturation and the degenerate case.
    logic                 vf_reg, df_reg;
    logic signed [QW:0]   vq_reg, wq_reg;
    logic [N_WEIGHT*WEIGHT_W-1:0] m_tdata_reg;
    logic [1:0]                   m_tuser_reg;

    function automatic logic [WEIGHT_W:0] sat_w(input logic signed [XW-1:0] x);
        logic [XW-WEIGHT_W:0] top;
        top = x[XW-1:WEIGHT_W-1];
        if ((top == '0) || (top == '1)) begin
            sat_w = {1'b0, x[WEIGHT_W-1:0]};
        end else if (x[XW-1]) begin
            sat_w = {1'b1, 1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            sat_w = {1'b1, 1'b0, {(WEIGHT_W-1){1'b1}}};
        end
    endfunction

    logic signed [XW-1:0] uq;
    logic [WEIGHT_W:0]    su, sv_w, sw_w;
    assign uq   = (XW'(1) <<< OUT_FRAC) - XW'(vq_reg) - XW'(wq_reg);
    assign su   = sat_w(uq);
    assign sv_w = sat_w(XW'(vq_reg));
    assign sw_w = sat_w(XW'(wq_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            vq_reg <= sv_reg[QW] ? -$signed({1'b0, qv_reg[QW]}) : $signed({1'b0, qv_reg[QW]});
            wq_reg <= sw_reg[QW] ? -$signed({1'b0, qw_reg[QW]}) : $signed({1'b0, qw_reg[QW]});
            df_reg <= dg_reg[QW];
            if (df_reg) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b01;
            end else begin
                m_tdata_reg <= {sw_w[WEIGHT_W-1:0], sv_w[WEIGHT_W-1:0], su[WEIGHT_W-1:0]};
                m_tuser_reg <= {su[WEIGHT_W] | sv_w[WEIGHT_W] | sw_w[WEIGHT_W], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            vf_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i <= QW; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            dv_reg[0] <= v6_reg;
            for (int i = 0; i < QW; i++) begin
                dv_reg[i+1] <= dv_reg[i];
            end
            vf_reg       <= dv_reg[QW];
            m_tvalid_reg <= vf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    logic [WEIGHT_W-1:0] out_u, out_v, out_w, out_sum;
    assign out_u   = m_tdata_reg[0 +: WEIGHT_W];
    assign out_v   = m_tdata_reg[WEIGHT_W +: WEIGHT_W];
    assign out_w   = m_tdata_reg[2*WEIGHT_W +: WEIGHT_W];
    assign out_sum = out_u + out_v + out_w;

    localparam logic [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[USER_DEGEN] |-> (m_tdata_reg == '0) && !m_tuser_reg[USER_SAT])
        else $error("degenerate word carries weights or saturation");

    a_weights_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg[USER_DEGEN] && !m_tuser_reg[USER_SAT]
        |-> out_sum == (WEIGHT_W'(1) << OUT_FRAC))
        else $error("unclipped weights do not sum to one");

    a_sat_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[USER_SAT]
        |-> (out_u == W_MAX) || (out_u == W_MIN) || (out_v == W_MAX) || (out_v == W_MIN)
            || (out_w == W_MAX) || (out_w == W_MIN))
        else $error("saturation flagged but no weight at a range end");

endmodule
